// ----- hdl/ir_remote_frame_encoder_core_defines.svh -----
// assertion macros used by the checker file
`ifndef IR_REMOTE_FRAME_ENCODER_CORE_DEFINES_SVH
`define IR_REMOTE_FRAME_ENCODER_CORE_DEFINES_SVH

// plain property check under the active-low reset
`define IRFE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// a signal holds for the next cycle whenever the condition is seen
`define IRFE_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ----- hdl/irfe_pkg.sv -----
// types, constants and helpers shared by the ir frame encoder modules
`timescale 1ns / 1ps
package irfe_pkg;

  localparam int unsigned FIELD_WIDTH_DEF      = 16;
  localparam int unsigned UNIT_COUNT_WIDTH_DEF = 5;

  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [2:0] NEC_ONE_UNITS  = 3'd4;
  localparam logic [2:0] SIRC_ONE_UNITS = 3'd3;
  localparam logic [2:0] ZERO_UNITS     = 3'd2;

  typedef enum logic [2:0] {
    SEG_HEAD_MARK  = 3'd0,
    SEG_HEAD_SPACE = 3'd1,
    SEG_FIELD_A    = 3'd2,
    SEG_FIELD_B    = 3'd3,
    SEG_FIELD_C    = 3'd4,
    SEG_FIELD_D    = 3'd5,
    SEG_TRAILER    = 3'd6,
    SEG_END        = 3'd7
  } seg_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PROTOCOL_MODE = 3'd0,
    CFG_HDR_MARK      = 3'd1,
    CFG_HDR_GAP       = 3'd2,
    CFG_REPEAT_SPACE  = 3'd3,
    CFG_ADDRESS_BITS  = 3'd4,
    CFG_COMMAND_BITS  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic       sirc;
    logic [4:0] hdr_mark;
    logic [4:0] hdr_gap;
    logic [4:0] repeat_space;
    logic [4:0] address_bits;
    logic [4:0] command_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sirc:         1'b0,
    hdr_mark:     5'd16,
    hdr_gap:      5'd8,
    repeat_space: 5'd4,
    address_bits: 5'd8,
    command_bits: 5'd8
  };

  function automatic logic is_field(seg_e s);
    return (s >= SEG_FIELD_A) && (s <= SEG_FIELD_D);
  endfunction

  // raw segment length: units for header and trailer, bits for fields
  function automatic logic [4:0] seg_len(seg_e s, cfg_t c, logic rep_latched);
    logic rep;
    logic [4:0] len;
    rep = rep_latched && !c.sirc;
    case (s)
      SEG_HEAD_MARK:  len = c.hdr_mark;
      SEG_HEAD_SPACE: len = rep ? c.repeat_space : c.hdr_gap;
      SEG_FIELD_A:    len = rep ? 5'd0 : (c.sirc ? c.command_bits : c.address_bits);
      SEG_FIELD_B:    len = rep ? 5'd0 : c.address_bits;
      SEG_FIELD_C:    len = (rep || c.sirc) ? 5'd0 : c.command_bits;
      SEG_FIELD_D:    len = (rep || c.sirc) ? 5'd0 : c.command_bits;
      SEG_TRAILER:    len = c.sirc ? 5'd0 : 5'd1;
      default:        len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/irfe_skip.sv -----
// segment advance: leaves a finished segment and skips the empty ones after it
`timescale 1ns / 1ps
module irfe_skip import irfe_pkg::*; #(
  parameter int unsigned UNIT_COUNT_WIDTH = UNIT_COUNT_WIDTH_DEF
) (
  input  cfg_t                        cfg_i,
  input  logic                        rep_i,
  input  seg_e                        seg_i,
  input  logic [4:0]                  pos_i,
  input  logic [UNIT_COUNT_WIDTH-1:0] cnt_i,
  input  logic [1:0]                  phase_i,
  output seg_e                        seg_o,
  output logic [4:0]                  pos_o,
  output logic [UNIT_COUNT_WIDTH-1:0] cnt_o,
  output logic [1:0]                  phase_o
);

  localparam logic [7:0] UnitMax = 8'((1 << UNIT_COUNT_WIDTH) - 1);

  logic [6:0] nz;
  logic [4:0] len_raw;
  logic [7:0] len_ext;
  logic [7:0] len_sat;
  logic       keep;
  seg_e       nxt;

  always_comb begin
    for (int t = 0; t < 7; t++) begin
      nz[t] = seg_len(seg_e'(3'(t)), cfg_i, rep_i) != 5'd0;
    end
    len_raw = seg_len(seg_i, cfg_i, rep_i);
    len_ext = {3'b000, len_raw};
    // header and trailer lengths clip at what the unit counter can hold
    len_sat = (len_ext > UnitMax) ? UnitMax : len_ext;
    if (is_field(seg_i)) begin
      keep = pos_i < len_raw;
    end else begin
      keep = 8'(cnt_i) < len_sat;
    end
    nxt = SEG_END;
    for (int t = 6; t >= 0; t--) begin
      if ((3'(t) > seg_i) && nz[t]) begin
        nxt = seg_e'(3'(t));
      end
    end
  end

  always_comb begin
    if ((seg_i == SEG_END) || keep) begin
      seg_o   = seg_i;
      pos_o   = pos_i;
      cnt_o   = cnt_i;
      phase_o = phase_i;
    end else begin
      seg_o   = nxt;
      pos_o   = '0;
      cnt_o   = '0;
      phase_o = '0;
    end
  end

endmodule

// ----- hdl/ir_remote_frame_encoder_core.sv -----
// ir remote frame encoder top level: nec and sirc framing, one unit per tick word
//
// channel   dir  tdata (low bit up)                         tuser
// s_axis    in   address[15:0] command[31:16] repeat_req[32] action
// m_axis    out  mark[0] busy_res[1] frame_done[2] start_accepted[3]
// cfg       in   cfg_we_i / cfg_addr_i / cfg_wdata_i, one register per write
//
// every input word is handled combinationally: two segment-advance stages and the unit
// logic sit between the frame state and the result register
// a new word is taken each cycle while the result register is empty or drained
// a stalled result holds; input stalls only when the result register is full
// async reset clears frame state and loads register defaults, no clearing pass
`timescale 1ns / 1ps
module ir_remote_frame_encoder_core import irfe_pkg::*; #(
  parameter int unsigned FIELD_WIDTH      = FIELD_WIDTH_DEF,
  parameter int unsigned UNIT_COUNT_WIDTH = UNIT_COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // address[15:0], command[31:16], repeat_req[32], zero fill
  input  logic [S_TDATA_W-1:0]  s_axis_tdata_i,
  // action[0]
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // mark[0], busy_res[1], frame_done[2], start_accepted[3], zero fill
  output logic [M_TDATA_W-1:0]  m_axis_tdata_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW = UNIT_COUNT_WIDTH;
  localparam logic [6:0] FwLim = 7'(FIELD_WIDTH);

  cfg_t cfg_q, cfg_d;

  logic                   active_q, active_d;
  logic                   done_q, done_d;
  logic [FIELD_WIDTH-1:0] addr_q, addr_d;
  logic [FIELD_WIDTH-1:0] cmd_q, cmd_d;
  logic                   rep_q, rep_d;
  seg_e                   seg_q, seg_d;
  logic [4:0]             pos_q, pos_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [1:0]             phase_q, phase_d;

  logic                   out_valid_q, out_valid_d;
  logic [3:0]             out_data_q, out_data_d;

  logic accept;
  logic is_tick;

  // stage a inputs and outputs
  logic          a_rep;
  seg_e          a_seg_in, a_seg;
  logic [4:0]    a_pos_in, a_pos;
  logic [CW-1:0] a_cnt_in, a_cnt;
  logic [1:0]    a_phase_in, a_phase;

  // unit logic and stage b
  logic                   sirc;
  logic [FIELD_WIDTH-1:0] fsel, fval, fshift;
  logic                   finv, fbit;
  logic [2:0]             bunits;
  logic [1:0]             phase_inc;
  logic                   bit_end;
  logic                   unit_mark;
  seg_e                   b_seg_in, b_seg;
  logic [4:0]             b_pos_in, b_pos;
  logic [CW-1:0]          b_cnt_in, b_cnt;
  logic [1:0]             b_phase_in, b_phase;

  logic res_mark, res_done, res_acc;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_tick         = s_axis_tuser_i;
  assign sirc            = cfg_q.sirc;

  // while idle the stages see a fresh frame, while a frame runs they see the running one
  always_comb begin
    if (active_q) begin
      a_rep      = rep_q;
      a_seg_in   = seg_q;
      a_pos_in   = pos_q;
      a_cnt_in   = cnt_q;
      a_phase_in = phase_q;
    end else begin
      a_rep      = s_axis_tdata_i[32];
      a_seg_in   = SEG_HEAD_MARK;
      a_pos_in   = '0;
      a_cnt_in   = '0;
      a_phase_in = '0;
    end
  end

  irfe_skip #(.UNIT_COUNT_WIDTH(UNIT_COUNT_WIDTH)) u_skip_a (
    .cfg_i   (cfg_q),
    .rep_i   (a_rep),
    .seg_i   (a_seg_in),
    .pos_i   (a_pos_in),
    .cnt_i   (a_cnt_in),
    .phase_i (a_phase_in),
    .seg_o   (a_seg),
    .pos_o   (a_pos),
    .cnt_o   (a_cnt),
    .phase_o (a_phase)
  );

  // one unit of the current segment
  always_comb begin
    if (sirc) begin
      fsel = (a_seg == SEG_FIELD_A) ? cmd_q : addr_q;
      finv = 1'b0;
    end else begin
      fsel = (a_seg <= SEG_FIELD_B) ? addr_q : cmd_q;
      finv = (a_seg == SEG_FIELD_B) || (a_seg == SEG_FIELD_D);
    end
    fval   = finv ? ~fsel : fsel;
    fshift = fval >> a_pos;
    fbit   = fshift[0] && ({2'b00, a_pos} < FwLim);
    if (sirc) begin
      bunits = fbit ? SIRC_ONE_UNITS : ZERO_UNITS;
    end else begin
      bunits = fbit ? NEC_ONE_UNITS : ZERO_UNITS;
    end
    phase_inc = a_phase + 2'd1;
    bit_end   = (phase_inc == 2'd0) || ({1'b0, phase_inc} >= bunits);

    b_seg_in   = a_seg;
    b_pos_in   = a_pos;
    b_cnt_in   = a_cnt;
    b_phase_in = a_phase;
    if (is_field(a_seg)) begin
      // sirc one bit carries a second mark unit
      unit_mark  = (a_phase == 2'd0) || ((a_phase == 2'd1) && fbit && sirc);
      b_phase_in = bit_end ? 2'd0 : phase_inc;
      b_pos_in   = bit_end ? a_pos + 5'd1 : a_pos;
    end else begin
      unit_mark = a_seg != SEG_HEAD_SPACE;
      b_cnt_in  = a_cnt + CW'(1);
    end
  end

  irfe_skip #(.UNIT_COUNT_WIDTH(UNIT_COUNT_WIDTH)) u_skip_b (
    .cfg_i   (cfg_q),
    .rep_i   (rep_q),
    .seg_i   (b_seg_in),
    .pos_i   (b_pos_in),
    .cnt_i   (b_cnt_in),
    .phase_i (b_phase_in),
    .seg_o   (b_seg),
    .pos_o   (b_pos),
    .cnt_o   (b_cnt),
    .phase_o (b_phase)
  );

  // frame state update
  always_comb begin
    active_d = active_q;
    done_d   = done_q;
    addr_d   = addr_q;
    cmd_d    = cmd_q;
    rep_d    = rep_q;
    seg_d    = seg_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    phase_d  = phase_q;
    res_mark = 1'b0;
    res_done = 1'b0;
    res_acc  = 1'b0;
    if (accept) begin
      if (!is_tick) begin
        if (!active_q) begin
          res_acc  = 1'b1;
          active_d = 1'b1;
          done_d   = 1'b0;
          addr_d   = FIELD_WIDTH'(s_axis_tdata_i[15:0]);
          cmd_d    = FIELD_WIDTH'(s_axis_tdata_i[31:16]);
          rep_d    = s_axis_tdata_i[32];
          seg_d    = a_seg;
          pos_d    = a_pos;
          cnt_d    = a_cnt;
          phase_d  = a_phase;
        end
      end else if (active_q) begin
        if (a_seg == SEG_END) begin
          // empty frame: one space unit then done
          active_d = 1'b0;
          done_d   = 1'b1;
          seg_d    = a_seg;
          pos_d    = a_pos;
          cnt_d    = a_cnt;
          phase_d  = a_phase;
        end else begin
          res_mark = unit_mark;
          seg_d    = b_seg;
          pos_d    = b_pos;
          cnt_d    = b_cnt;
          phase_d  = b_phase;
          if (b_seg == SEG_END) begin
            active_d = 1'b0;
            done_d   = 1'b1;
          end
        end
      end else if (done_q) begin
        res_done = 1'b1;
        done_d   = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_data_d  = {res_acc, res_done, active_d, res_mark};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_PROTOCOL_MODE: cfg_d.sirc         = cfg_wdata_i[0];
        CFG_HDR_MARK:      cfg_d.hdr_mark     = cfg_wdata_i;
        CFG_HDR_GAP:       cfg_d.hdr_gap      = cfg_wdata_i;
        CFG_REPEAT_SPACE:  cfg_d.repeat_space = cfg_wdata_i;
        CFG_ADDRESS_BITS:  cfg_d.address_bits = cfg_wdata_i;
        CFG_COMMAND_BITS:  cfg_d.command_bits = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      active_q    <= 1'b0;
      done_q      <= 1'b0;
      addr_q      <= '0;
      cmd_q       <= '0;
      rep_q       <= 1'b0;
      seg_q       <= SEG_HEAD_MARK;
      pos_q       <= '0;
      cnt_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      active_q    <= active_d;
      done_q      <= done_d;
      addr_q      <= addr_d;
      cmd_q       <= cmd_d;
      rep_q       <= rep_d;
      seg_q       <= seg_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - 4){1'b0}}, out_data_q};

endmodule

// ----- hdl/irfe_checker.sv -----
// port-level checker for the ir frame encoder, bound to the top level
`timescale 1ns / 1ps
`include "ir_remote_frame_encoder_core_defines.svh"
module irfe_checker import irfe_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  // a stalled result word holds
  `IRFE_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tdata_o, "stalled result changed")

  // every accepted word shows up in the result register next cycle
  `IRFE_ASSERT(a_in_to_out, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o, "accepted word lost")

  // an empty result register never blocks the input
  `IRFE_ASSERT(a_ready_empty, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o, "input blocked while output empty")

  // an accepted start always leaves a frame running
  `IRFE_ASSERT(a_acc_busy, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[3] |-> m_axis_tdata_o[1], "start accepted without busy")

  // the done pulse comes on an idle tick only
  `IRFE_ASSERT(a_done_alone, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[2] |-> !m_axis_tdata_o[0] && !m_axis_tdata_o[1] && !m_axis_tdata_o[3], "done pulse mixed with other flags")

endmodule

bind ir_remote_frame_encoder_core irfe_checker u_irfe_checker (.*);

// ----- verif/tb_top.sv -----
// self-checking testbench for the nec / sirc ir remote frame encoder core
`timescale 1ns / 1ps
module tb_top import irfe_pkg::*; ();

  localparam logic        ACT_START      = 1'b0;
  localparam logic        ACT_TICK       = 1'b1;
  localparam int unsigned PAYLOAD_W      = 16;
  localparam int unsigned UNIT_MAX       = 31;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RAND_PHASES    = 8;
  localparam int unsigned PHASE_WORDS    = 40;

  typedef struct packed {
    logic accepted;
    logic done;
    logic busy;
    logic mark;
  } unit_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ir_remote_frame_encoder_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the encoder
  cfg_t         enc_cfg = CFG_RESET;
  logic         frm_active = 1'b0;
  logic         done_armed = 1'b0;
  logic         lat_rep = 1'b0;
  logic [15:0]  lat_addr = '0;
  logic [15:0]  lat_cmd = '0;
  seg_e         cur_seg = SEG_HEAD_MARK;
  int unsigned  bit_pos = 0;
  int unsigned  unit_cnt = 0;
  int unsigned  bit_step = 0;

  unit_result_t unit_q[$];
  unit_result_t exp_w;
  unit_result_t got_w;
  int unsigned  err_cnt = 0;
  int unsigned  words_sent = 0;
  int unsigned  frames_taken = 0;
  int unsigned  starts_refused = 0;
  int unsigned  done_pulses = 0;
  int unsigned  cfg_sets = 0;
  int unsigned  stall_cycles = 0;
  logic         no_idle = 1'b0;

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic carries_bits(seg_e s);
    return (s == SEG_FIELD_A) || (s == SEG_FIELD_B) || (s == SEG_FIELD_C) ||
           (s == SEG_FIELD_D);
  endfunction

  // header counts are 5-bit registers, so they never exceed the counter range
  function automatic int unsigned segment_length(seg_e s);
    logic        nec_rep;
    int unsigned n;
    nec_rep = lat_rep && !enc_cfg.sirc;
    n = 0;
    case (s)
      SEG_HEAD_MARK:  n = 32'(enc_cfg.hdr_mark);
      SEG_HEAD_SPACE: n = 32'(nec_rep ? enc_cfg.repeat_space : enc_cfg.hdr_gap);
      SEG_FIELD_A: begin
        if (!nec_rep) begin
          n = 32'(enc_cfg.sirc ? enc_cfg.command_bits : enc_cfg.address_bits);
        end
      end
      SEG_FIELD_B: begin
        if (!nec_rep) n = 32'(enc_cfg.address_bits);
      end
      SEG_FIELD_C, SEG_FIELD_D: begin
        if (!nec_rep && !enc_cfg.sirc) n = 32'(enc_cfg.command_bits);
      end
      SEG_TRAILER:    n = enc_cfg.sirc ? 0 : 1;
      default:        n = 0;
    endcase
    return n;
  endfunction

  function automatic logic payload_bit(seg_e s);
    logic [15:0] v;
    if (bit_pos >= PAYLOAD_W) return 1'b0;
    if (enc_cfg.sirc) begin
      v = (s == SEG_FIELD_A) ? lat_cmd : lat_addr;
    end else begin
      v = (s == SEG_FIELD_A || s == SEG_FIELD_B) ? lat_addr : lat_cmd;
      if (s == SEG_FIELD_B || s == SEG_FIELD_D) v = ~v;
    end
    return v[bit_pos];
  endfunction

  function automatic int unsigned units_per_bit(logic b);
    if (enc_cfg.sirc) return b ? 3 : 2;
    return b ? 4 : 2;
  endfunction

  function automatic void skip_finished_segments();
    int unsigned pos;
    while (cur_seg != SEG_END) begin
      pos = carries_bits(cur_seg) ? bit_pos : unit_cnt;
      if (pos < segment_length(cur_seg)) break;
      cur_seg  = seg_e'(cur_seg + 3'd1);
      bit_pos  = 0;
      unit_cnt = 0;
      bit_step = 0;
    end
  endfunction

  function automatic unit_result_t predict_word(logic action, logic [15:0] addr,
                                                logic [15:0] cmd, logic rep);
    unit_result_t r;
    logic         b;
    r = '0;
    if (action == ACT_START) begin
      if (!frm_active) begin
        r.accepted = 1'b1;
        frm_active = 1'b1;
        done_armed = 1'b0;
        lat_addr   = addr;
        lat_cmd    = cmd;
        lat_rep    = rep;
        cur_seg    = SEG_HEAD_MARK;
        bit_pos    = 0;
        unit_cnt   = 0;
        bit_step   = 0;
        skip_finished_segments();
      end
    end else if (frm_active) begin
      skip_finished_segments();
      if (cur_seg != SEG_END) begin
        if (carries_bits(cur_seg)) begin
          b = payload_bit(cur_seg);
          r.mark = (bit_step == 0) || (bit_step == 1 && b && enc_cfg.sirc);
          bit_step = (bit_step + 1) & 3;
          if (bit_step == 0 || bit_step >= units_per_bit(b)) begin
            bit_step = 0;
            bit_pos  = (bit_pos + 1) & 31;
          end
        end else begin
          r.mark   = (cur_seg != SEG_HEAD_SPACE);
          unit_cnt = (unit_cnt + 1) & UNIT_MAX;
        end
        skip_finished_segments();
      end
      // a frame ends here once no segment is left; an empty frame ends on its single space unit
      if (cur_seg == SEG_END) begin
        frm_active = 1'b0;
        done_armed = 1'b1;
      end
    end else if (done_armed) begin
      r.done     = 1'b1;
      done_armed = 1'b0;
    end
    r.busy = frm_active;
    return r;
  endfunction

  task automatic send_word(input logic action, input logic [15:0] addr,
                           input logic [15:0] cmd, input logic rep);
    int unsigned  gap;
    unit_result_t pred;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = action;
    s_axis_tdata_i  = {7'b0, rep, cmd, addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_word(action, addr, cmd, rep);
    unit_q.push_back(pred);
    words_sent++;
    if (action == ACT_START) begin
      if (pred.accepted) frames_taken++;
      else starts_refused++;
    end
    if (pred.done) done_pulses++;
  endtask

  // ticks carry random payload that the block must ignore
  task automatic tick_word();
    send_word(ACT_TICK, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_out_frame();
    while (frm_active) tick_word();
  endtask

  task automatic settle_idle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [4:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_PROTOCOL_MODE: enc_cfg.sirc         = val[0];
      CFG_HDR_MARK:      enc_cfg.hdr_mark     = val;
      CFG_HDR_GAP:       enc_cfg.hdr_gap      = val;
      CFG_REPEAT_SPACE:  enc_cfg.repeat_space = val;
      CFG_ADDRESS_BITS:  enc_cfg.address_bits = val;
      CFG_COMMAND_BITS:  enc_cfg.command_bits = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input cfg_t c);
    settle_idle();
    write_reg(CFG_PROTOCOL_MODE, {4'b0, c.sirc});
    write_reg(CFG_HDR_MARK, c.hdr_mark);
    write_reg(CFG_HDR_GAP, c.hdr_gap);
    write_reg(CFG_REPEAT_SPACE, c.repeat_space);
    write_reg(CFG_ADDRESS_BITS, c.address_bits);
    write_reg(CFG_COMMAND_BITS, c.command_bits);
    cfg_sets++;
  endtask

  function automatic cfg_t random_phase_cfg(int p);
    cfg_t c;
    case (p)
      0:       c = '{1'b0, 5'd1, 5'd0, 5'd0, 5'd1, 5'd1};
      1:       c = '{1'b0, 5'd31, 5'd31, 5'd31, 5'd16, 5'd16};
      2:       c = '{1'b1, 5'd31, 5'd31, 5'd31, 5'd16, 5'd16};
      3:       c = '{1'b0, 5'd3, 5'd2, 5'd1, 5'd31, 5'd20};
      default: begin
        c.sirc         = 1'($urandom_range(0, 1));
        c.hdr_mark     = 5'($urandom_range(1, 8));
        c.hdr_gap      = 5'($urandom_range(0, 8));
        c.repeat_space = 5'($urandom_range(0, 8));
        c.address_bits = 5'($urandom_range(1, 12));
        c.command_bits = 5'($urandom_range(1, 12));
      end
    endcase
    return c;
  endfunction

  // one frame on the power-up register values
  task automatic test_reset_frame();
    send_word(ACT_START, 16'($urandom), 16'($urandom), 1'b0);
    run_out_frame();
    tick_word();
  endtask

  task automatic test_nec_basic();
    set_config('{1'b0, 5'd1, 5'd2, 5'd1, 5'd1, 5'd1});
    tick_word();
    send_word(ACT_START, 16'hFFFF, 16'h0000, 1'b0);
    // start during a frame is refused
    send_word(ACT_START, 16'h0000, 16'hFFFF, 1'b1);
    run_out_frame();
    tick_word();
    tick_word();
  endtask

  task automatic test_nec_repeat();
    send_word(ACT_START, 16'hFFFF, 16'hFFFF, 1'b1);
    run_out_frame();
    // start while the done pulse is still owed drops the pulse
    send_word(ACT_START, 16'h0000, 16'hFFFF, 1'b0);
    run_out_frame();
    tick_word();
  endtask

  task automatic test_sirc_edges();
    set_config('{1'b1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0});
    // nothing to send: one space unit, then done; repeat has no effect in sirc
    send_word(ACT_START, 16'hFFFF, 16'hFFFF, 1'b1);
    run_out_frame();
    tick_word();
    // field lengths past the payload width send zeros
    set_config('{1'b1, 5'd2, 5'd1, 5'd0, 5'd18, 5'd17});
    send_word(ACT_START, 16'hFFFF, 16'hFFFF, 1'b1);
    run_out_frame();
    tick_word();
  endtask

  task automatic test_random_frames();
    int unsigned phase_end;
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_config(random_phase_cfg(p));
      no_idle   = (p % 3 == 2);
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) tick_word();
        send_word(ACT_START, 16'($urandom), 16'($urandom), $urandom_range(0, 3) == 0);
        while (frm_active) begin
          if ($urandom_range(0, 15) == 0) begin
            send_word(ACT_START, 16'($urandom), 16'($urandom),
                      1'($urandom_range(0, 1)));
          end else begin
            tick_word();
          end
        end
        if ($urandom_range(0, 2) != 0) tick_word();
      end
      no_idle = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic exp_v, input logic got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = ACT_TICK;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CFG_PROTOCOL_MODE;
    cfg_wdata_i     = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_frame();
    test_nec_basic();
    test_nec_repeat();
    test_sirc_edges();
    test_random_frames();

    settle_idle();
    repeat (8) @(posedge clk_i);
    if (unit_q.size() != 0) begin
      $error("%0d predicted words never came out", unit_q.size());
      err_cnt++;
    end
    $display("covered %0d words: %0d frames started, %0d starts refused, %0d done pulses",
             words_sent, frames_taken, starts_refused, done_pulses);
    $display("over %0d register settings in nec and sirc, random stalls on both sides",
             cfg_sets);
    if (err_cnt == 0) begin
      $display("ir_remote_frame_encoder_core verification clean");
    end else begin
      $display("ir_remote_frame_encoder_core verification failed");
    end
    $finish;
  end

  // result side: random back-pressure per word
  initial begin
    int unsigned gap;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (unit_q.size() == 0) begin
        $error("result word with no prediction pending");
        err_cnt++;
      end else begin
        exp_w = unit_q.pop_front();
        got_w = m_axis_tdata_o[3:0];
        check_field("mark", exp_w.mark, got_w.mark);
        check_field("busy_res", exp_w.busy, got_w.busy);
        check_field("frame_done", exp_w.done, got_w.done);
        check_field("start_accepted", exp_w.accepted, got_w.accepted);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("ir_remote_frame_encoder_core verification failed");
        $finish;
      end
    end
  end

endmodule
